/* hw/rtl/mwds_pkg.sv */
// ----------------------------------------------------------------------------
// mwds_pkg: shared types and constants of the dependency scheduler
// Command and result codes, payload structs, controller interface structs.
// ----------------------------------------------------------------------------
package mwds_pkg;

	localparam int NumTasks   = 26;
	localparam int NumWorkers = 5;
	localparam int TaskW      = 5;
	localparam int WorkerW    = 3;
	localparam int RemW       = 9;
	localparam int TimeW      = 16;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_RUN   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_DONE     = 2'd0,
		KIND_FINISHED = 2'd1,
		KIND_DEADLOCK = 2'd2
	} kind_t;

	localparam logic CFG_BASE    = 1'b0;
	localparam logic CFG_WORKERS = 1'b1;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [TaskW-1:0] before_task;
		logic [TaskW-1:0] after_task;
	} request_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [TaskW-1:0] task_index;
		logic [TimeW-1:0] finish_time;
		logic             last;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic load_req;   // capture request, handle add/clear
		logic run_init;   // start a run
		logic dec;        // count down busy workers
		logic retire;     // retire worker wsel if done
		logic assign_w;   // assign a ready task to worker wsel if free
		logic tick_inc;   // advance tick
		logic emit_end;   // emit finish or deadlock
		logic [WorkerW-1:0] wsel;
	} ctrl_t;

	// datapath -> controller
	typedef struct packed {
		logic is_run;
		logic left_zero;
		logic any_busy;
		logic [WorkerW-1:0] nw_last;
	} stat_t;

endpackage

/* hw/rtl/mwds_ctrl.sv */
// ----------------------------------------------------------------------------
// mwds_ctrl: scheduler sequencer
// Steps through decrement, per-worker retire, per-worker assign and check each tick.
// ----------------------------------------------------------------------------
module mwds_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  mwds_pkg::stat_t  stat,
	output mwds_pkg::ctrl_t  ctrl
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DECODE = 6'b000010,
		ST_DEC    = 6'b000100,
		ST_RET    = 6'b001000,
		ST_ASG    = 6'b010000,
		ST_CHECK  = 6'b100000
	} state_t;

	state_t state_q;
	logic [mwds_pkg::WorkerW-1:0] w_q;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		ctrl = '0;
		ctrl.wsel = w_q;
		ctrl.load_req = (state_q == ST_IDLE) && start;
		unique case (state_q)
			ST_DECODE: ctrl.run_init = stat.is_run;
			ST_DEC:    ctrl.dec = 1'b1;
			ST_RET:    ctrl.retire = 1'b1;
			ST_ASG:    ctrl.assign_w = 1'b1;
			ST_CHECK: begin
				ctrl.emit_end = stat.left_zero || !stat.any_busy;
				ctrl.tick_inc = !ctrl.emit_end;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			w_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE:   if (start) state_q <= ST_DECODE;
				ST_DECODE: state_q <= stat.is_run ? ST_DEC : ST_IDLE;
				ST_DEC: begin
					w_q     <= '0;
					state_q <= ST_RET;
				end
				ST_RET: begin
					if (w_q == stat.nw_last) begin
						w_q     <= '0;
						state_q <= stat.left_zero ? ST_CHECK : ST_ASG;
					end else begin
						w_q <= w_q + 1'b1;
					end
				end
				ST_ASG: begin
					if (w_q == stat.nw_last) state_q <= ST_CHECK;
					else w_q <= w_q + 1'b1;
				end
				ST_CHECK: state_q <= ctrl.emit_end ? ST_IDLE : ST_DEC;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/mwds_datapath.sv */
// ----------------------------------------------------------------------------
// mwds_datapath: edge store, worker registers and ready search
// Holds the successor matrix, pending counts and run state.
// ----------------------------------------------------------------------------
module mwds_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  mwds_pkg::request_t request,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data,
	input  mwds_pkg::ctrl_t    ctrl,
	output mwds_pkg::stat_t    stat,
	output logic               result_valid,
	output mwds_pkg::result_t  result
);

	localparam int NT = mwds_pkg::NumTasks;
	localparam int NW = mwds_pkg::NumWorkers;
	localparam int TW = mwds_pkg::TaskW;

	logic [NT-1:0] succ_q [NT];
	logic [TW-1:0] pend_q [NT];
	logic [TW-1:0] work_q [NT];
	logic [NT-1:0] started_q;
	logic [TW-1:0] wtask_q [NW];
	logic [NW-1:0] wbusy_q;
	logic [mwds_pkg::RemW-1:0] wrem_q [NW];
	logic [mwds_pkg::TimeW-1:0] tick_q;
	logic [TW-1:0] left_q;
	logic [7:0] base_q;
	logic [2:0] nwcfg_q;
	logic [1:0] cmd_q;
	logic [mwds_pkg::WorkerW-1:0] nw_last;

	logic          rdy_found;
	logic [TW-1:0] rdy_idx;
	logic [NT-1:0] row_sel;
	logic          ret_hit;

	always_comb begin
		if (nwcfg_q == 3'd0) nw_last = '0;
		else if (nwcfg_q > 3'(NW)) nw_last = 3'(NW - 1);
		else nw_last = nwcfg_q - 3'd1;
	end

	always_comb begin
		rdy_found = 1'b0;
		rdy_idx   = '0;
		for (int t = NT - 1; t >= 0; t--) begin
			if (!started_q[t] && work_q[t] == '0) begin
				rdy_found = 1'b1;
				rdy_idx   = TW'(t);
			end
		end
	end

	assign ret_hit = ctrl.retire && wbusy_q[ctrl.wsel] && wrem_q[ctrl.wsel] == '0;
	assign row_sel = succ_q[wtask_q[ctrl.wsel]];

	assign stat.is_run    = (cmd_q == mwds_pkg::CMD_RUN);
	assign stat.left_zero = (left_q == '0);
	assign stat.any_busy  = |wbusy_q;
	assign stat.nw_last   = nw_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NT; t++) begin
				succ_q[t] <= '0;
				pend_q[t] <= '0;
				work_q[t] <= '0;
			end
			for (int w = 0; w < NW; w++) begin
				wtask_q[w] <= '0;
				wrem_q[w]  <= '0;
			end
			started_q    <= '0;
			wbusy_q      <= '0;
			tick_q       <= '0;
			left_q       <= '0;
			base_q       <= 8'd60;
			nwcfg_q      <= 3'd5;
			cmd_q        <= '0;
			result_valid <= 1'b0;
			result       <= '0;
		end else begin
			result_valid <= ret_hit || ctrl.emit_end;
			if (cfg_we) begin
				if (cfg_index == mwds_pkg::CFG_BASE) base_q <= cfg_data;
				else nwcfg_q <= cfg_data[2:0];
			end
			if (ctrl.load_req) begin
				cmd_q <= request.cmd;
				if (request.cmd == mwds_pkg::CMD_ADD) begin
					if (request.before_task < TW'(NT) && request.after_task < TW'(NT)
						&& !succ_q[request.before_task][request.after_task]) begin
						succ_q[request.before_task][request.after_task] <= 1'b1;
						pend_q[request.after_task] <= pend_q[request.after_task] + 1'b1;
					end
				end else if (request.cmd == mwds_pkg::CMD_CLEAR) begin
					for (int t = 0; t < NT; t++) begin
						succ_q[t] <= '0;
						pend_q[t] <= '0;
					end
				end
			end
			if (ctrl.run_init) begin
				for (int t = 0; t < NT; t++) work_q[t] <= pend_q[t];
				started_q <= '0;
				wbusy_q   <= '0;
				for (int w = 0; w < NW; w++) begin
					wtask_q[w] <= '0;
					wrem_q[w]  <= '0;
				end
				tick_q <= '0;
				left_q <= TW'(NT);
			end
			if (ctrl.dec) begin
				for (int w = 0; w < NW; w++)
					if (3'(w) <= nw_last && wbusy_q[w] && wrem_q[w] != '0)
						wrem_q[w] <= wrem_q[w] - 1'b1;
			end
			if (ret_hit) begin
				for (int t = 0; t < NT; t++)
					if (row_sel[t] && work_q[t] != '0) work_q[t] <= work_q[t] - 1'b1;
				wbusy_q[ctrl.wsel] <= 1'b0;
				if (left_q != '0) left_q <= left_q - 1'b1;
				result <= {mwds_pkg::KIND_DONE, wtask_q[ctrl.wsel], tick_q, 1'b0};
			end
			if (ctrl.assign_w && !wbusy_q[ctrl.wsel] && rdy_found) begin
				started_q[rdy_idx]  <= 1'b1;
				wtask_q[ctrl.wsel]  <= rdy_idx;
				wbusy_q[ctrl.wsel]  <= 1'b1;
				wrem_q[ctrl.wsel]   <= {1'b0, base_q} + 9'd1 + {4'd0, rdy_idx};
			end
			if (ctrl.tick_inc) tick_q <= tick_q + 1'b1;
			if (ctrl.emit_end) begin
				result <= {(left_q == '0) ? mwds_pkg::KIND_FINISHED : mwds_pkg::KIND_DEADLOCK,
					TW'(0), tick_q, 1'b1};
			end
		end
	end

endmodule

/* hw/rtl/multi_worker_dependency_scheduler_top.sv */
// ----------------------------------------------------------------------------
// multi_worker_dependency_scheduler_top: task scheduler over loaded edges
// Usage:
//   A request is taken when start is high and busy is low. Add edge and
//   clear requests update the edge store and hold busy high for one cycle.
//   A run request simulates the workers tick by tick: each tick steps
//   through decrement, retire pass, assign pass and check over the
//   enabled workers, the retire and assign passes walking the workers
//   one per cycle. The closing result is registered from the check step
//   and appears in the cycle after the last one with busy high.
//   Every completion appears on result with result_valid high for one
//   cycle; the run ends with a finished or deadlock result with last set.
//   Results cannot be stalled; the receiver must take each one.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
//   and are to be made while busy is low.
//   Reset clears edges, counts and worker state; base is 60, workers 5.
// ----------------------------------------------------------------------------
module multi_worker_dependency_scheduler_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  mwds_pkg::request_t request,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data,
	output logic               result_valid,
	output mwds_pkg::result_t  result
);

	mwds_pkg::ctrl_t ctrl;
	mwds_pkg::stat_t stat;

	mwds_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	mwds_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.request      (request),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.ctrl         (ctrl),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

/* bench/tb_multi_worker_dependency_scheduler_top.sv */
// ----------------------------------------------------------------------------
// tb_multi_worker_dependency_scheduler_top: self-checking bench of the scheduler
// Loads precedence graphs, runs schedules under several base durations and
// worker counts, and compares every completion, finish and deadlock result
// against an in-bench schedule predictor. Directed corner cases come first,
// then random graphs with noise requests and random gaps on the request side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multi_worker_dependency_scheduler_top;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	mwds_pkg::request_t request;
	logic               cfg_we;
	logic               cfg_index;
	logic [7:0]         cfg_data;
	logic               result_valid;
	mwds_pkg::result_t  result;

	multi_worker_dependency_scheduler_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_valid(result_valid), .result(result)
	);

	logic [mwds_pkg::NumTasks-1:0] succ_rows [mwds_pkg::NumTasks];
	int                            pend_cnt  [mwds_pkg::NumTasks];
	int                            base_ticks;
	int                            worker_cfg;
	mwds_pkg::result_t             sched_q [$];
	int                            mismatches;
	int                            items_sent;
	bit                            no_idle;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("** multi_worker_dependency_scheduler_top: FAILED **");
		$finish;
	end

	function automatic mwds_pkg::result_t make_result(mwds_pkg::kind_t k, int t, int tick,
		bit lst);
		mwds_pkg::result_t r;
		r.kind        = k;
		r.task_index  = t[mwds_pkg::TaskW-1:0];
		r.finish_time = tick[mwds_pkg::TimeW-1:0];
		r.last        = lst;
		return r;
	endfunction

	function automatic void expect_result(mwds_pkg::result_t r);
		sched_q.insert(sched_q.size(), r);
	endfunction

	function automatic void schedule_run();
		int work [mwds_pkg::NumTasks];
		bit started [mwds_pkg::NumTasks];
		bit wbusy [mwds_pkg::NumWorkers];
		int wtask [mwds_pkg::NumWorkers];
		int wrem [mwds_pkg::NumWorkers];
		int nw, tick, left;
		bit any_busy;
		nw = worker_cfg;
		if (nw < 1) nw = 1;
		if (nw > mwds_pkg::NumWorkers) nw = mwds_pkg::NumWorkers;
		for (int t = 0; t < mwds_pkg::NumTasks; t++) begin
			work[t] = pend_cnt[t];
			started[t] = 0;
		end
		for (int w = 0; w < mwds_pkg::NumWorkers; w++) begin
			wbusy[w] = 0;
			wtask[w] = 0;
			wrem[w] = 0;
		end
		tick = 0;
		left = mwds_pkg::NumTasks;
		forever begin
			any_busy = 0;
			for (int w = 0; w < nw; w++)
				if (wbusy[w] && wrem[w] > 0) wrem[w]--;
			for (int w = 0; w < nw; w++) begin
				if (wbusy[w] && wrem[w] == 0) begin
					for (int t = 0; t < mwds_pkg::NumTasks; t++)
						if (succ_rows[wtask[w]][t] && work[t] > 0) work[t]--;
					expect_result(make_result(mwds_pkg::KIND_DONE, wtask[w], tick, 0));
					wbusy[w] = 0;
					if (left > 0) left--;
				end
			end
			if (left == 0) begin
				expect_result(make_result(mwds_pkg::KIND_FINISHED, 0, tick, 1));
				return;
			end
			for (int w = 0; w < nw; w++) begin
				if (!wbusy[w]) begin
					for (int t = 0; t < mwds_pkg::NumTasks; t++) begin
						if (!started[t] && work[t] == 0) begin
							started[t] = 1;
							wtask[w] = t;
							wbusy[w] = 1;
							wrem[w] = base_ticks + 1 + t;
							break;
						end
					end
				end
				if (wbusy[w]) any_busy = 1;
			end
			if (!any_busy) begin
				expect_result(make_result(mwds_pkg::KIND_DEADLOCK, 0, tick, 1));
				return;
			end
			tick++;
		end
	endfunction

	function automatic void predict_request(mwds_pkg::request_t r);
		case (r.cmd)
			mwds_pkg::CMD_ADD: begin
				if (r.before_task < mwds_pkg::NumTasks && r.after_task < mwds_pkg::NumTasks &&
				    !succ_rows[r.before_task][r.after_task]) begin
					succ_rows[r.before_task][r.after_task] = 1'b1;
					pend_cnt[r.after_task]++;
				end
			end
			mwds_pkg::CMD_RUN: schedule_run();
			mwds_pkg::CMD_CLEAR: begin
				for (int t = 0; t < mwds_pkg::NumTasks; t++) begin
					succ_rows[t] = '0;
					pend_cnt[t] = 0;
				end
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (sched_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result kind=%0d task=%0d time=%0d last=%0d",
					         result.kind, result.task_index, result.finish_time, result.last);
			end else begin
				if (result !== sched_q[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch exp kind=%0d task=%0d time=%0d last=%0d,",
						          " got kind=%0d task=%0d time=%0d last=%0d"},
						         sched_q[0].kind, sched_q[0].task_index,
						         sched_q[0].finish_time, sched_q[0].last,
						         result.kind, result.task_index, result.finish_time,
						         result.last);
				end
				void'(sched_q.pop_front());
			end
		end
	end

	task automatic send_request(logic [1:0] c, logic [4:0] b, logic [4:0] a);
		mwds_pkg::request_t r;
		int gap;
		r.cmd = c;
		r.before_task = b;
		r.after_task = a;
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		predict_request(r);
		items_sent++;
		gap = 0;
		if (!no_idle && $urandom_range(0, 9) >= 6)
			gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (sched_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic set_config(int base, int workers);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= mwds_pkg::CFG_BASE;
		cfg_data <= base[7:0];
		@(posedge clk);
		base_ticks = base & 8'hFF;
		cfg_index <= mwds_pkg::CFG_WORKERS;
		cfg_data <= workers[7:0];
		@(posedge clk);
		worker_cfg = workers & 7;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_defaults();
		send_request(mwds_pkg::CMD_RUN, 5'd0, 5'd0);
		drain_results();
	endtask

	task automatic test_edge_rules();
		set_config(0, 5);
		send_request(mwds_pkg::CMD_ADD, 5'd0, 5'd1);
		send_request(mwds_pkg::CMD_ADD, 5'd0, 5'd1);
		send_request(mwds_pkg::CMD_ADD, 5'd31, 5'd2);
		send_request(mwds_pkg::CMD_ADD, 5'd3, 5'd26);
		send_request(mwds_pkg::CMD_ADD, 5'd1, 5'd25);
		send_request(mwds_pkg::CMD_NONE, 5'd31, 5'd31);
		send_request(mwds_pkg::CMD_RUN, 5'd0, 5'd0);
		send_request(mwds_pkg::CMD_RUN, 5'd0, 5'd0);
		send_request(mwds_pkg::CMD_ADD, 5'd4, 5'd4);
		send_request(mwds_pkg::CMD_RUN, 5'd0, 5'd0);
		send_request(mwds_pkg::CMD_CLEAR, 5'd0, 5'd0);
		send_request(mwds_pkg::CMD_ADD, 5'd2, 5'd0);
		send_request(mwds_pkg::CMD_ADD, 5'd0, 5'd2);
		send_request(mwds_pkg::CMD_RUN, 5'd0, 5'd0);
		send_request(mwds_pkg::CMD_CLEAR, 5'd0, 5'd0);
	endtask

	task automatic test_worker_limits();
		set_config(255, 0);
		send_request(mwds_pkg::CMD_RUN, 5'd0, 5'd0);
		set_config(3, 7);
		send_request(mwds_pkg::CMD_ADD, 5'd10, 5'd20);
		send_request(mwds_pkg::CMD_RUN, 5'd0, 5'd0);
		set_config(0, 6);
		send_request(mwds_pkg::CMD_RUN, 5'd0, 5'd0);
		set_config(1, 1);
		send_request(mwds_pkg::CMD_RUN, 5'd0, 5'd0);
		send_request(mwds_pkg::CMD_CLEAR, 5'd0, 5'd0);
	endtask

	task automatic test_random_graphs();
		int base, n_edges, b, a;
		while (items_sent < 200) begin
			base = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12) : $urandom_range(0, 255);
			set_config(base, $urandom_range(0, 7));
			no_idle = ($urandom_range(0, 3) == 0);
			send_request(mwds_pkg::CMD_CLEAR, 5'($urandom), 5'($urandom));
			n_edges = $urandom_range(0, 16);
			for (int i = 0; i < n_edges; i++) begin
				case ($urandom_range(0, 19))
					0: send_request(mwds_pkg::CMD_ADD, 5'($urandom), 5'($urandom));
					1: send_request(mwds_pkg::CMD_NONE, 5'($urandom), 5'($urandom));
					2: begin
						b = $urandom_range(0, mwds_pkg::NumTasks - 1);
						send_request(mwds_pkg::CMD_ADD, 5'(b), 5'(b));
					end
					3: send_request(mwds_pkg::CMD_ADD, 5'($urandom_range(0, 25)),
						5'($urandom_range(0, 25)));
					default: begin
						b = $urandom_range(0, mwds_pkg::NumTasks - 2);
						a = $urandom_range(b + 1, mwds_pkg::NumTasks - 1);
						send_request(mwds_pkg::CMD_ADD, 5'(b), 5'(a));
					end
				endcase
			end
			send_request(mwds_pkg::CMD_RUN, 5'($urandom), 5'($urandom));
			if ($urandom_range(0, 3) == 0)
				send_request(mwds_pkg::CMD_RUN, 5'($urandom), 5'($urandom));
			if ($urandom_range(0, 4) == 0) drain_results();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		mismatches = 0;
		items_sent = 0;
		no_idle = 0;
		base_ticks = 60;
		worker_cfg = 5;
		for (int t = 0; t < mwds_pkg::NumTasks; t++) begin
			succ_rows[t] = '0;
			pend_cnt[t] = 0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_edge_rules();
		test_worker_limits();
		test_random_graphs();
		drain_results();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && sched_q.size() == 0)
			$display("** multi_worker_dependency_scheduler_top: PASSED **");
		else
			$display("** multi_worker_dependency_scheduler_top: FAILED **");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/mwds_pkg.sv
hw/rtl/mwds_ctrl.sv
hw/rtl/mwds_datapath.sv
hw/rtl/multi_worker_dependency_scheduler_top.sv
bench/tb_multi_worker_dependency_scheduler_top.sv
